/* sv/palette_lut_port_and_pixel_expand_unit_assert.svh */
// Assertion shorthands used by the top-level RTL; clk and rst_n must be in scope.
`ifndef PALETTE_LUT_PORT_AND_PIXEL_EXPAND_UNIT_ASSERT_SVH
`define PALETTE_LUT_PORT_AND_PIXEL_EXPAND_UNIT_ASSERT_SVH

// condition must never hold outside reset
`define PLPX_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define PLPX_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLPX_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/plpx_pkg.sv */
package plpx_pkg;

    localparam int LUT_ENTRIES = 256;
    localparam int LUT_IDX_W   = (LUT_ENTRIES > 1) ? $clog2(LUT_ENTRIES) : 1;
    localparam int ADDR_W      = 8;
    localparam logic [ADDR_W:0] LUT_LIMIT = (ADDR_W + 1)'(LUT_ENTRIES);

    // input item actions
    localparam logic [1:0] ACT_SET_ADDR = 2'd0;
    localparam logic [1:0] ACT_WRITE    = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;
    localparam logic [1:0] ACT_EXPAND   = 2'd3;

    // result kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // colour phases
    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_BLUE  = 2'd2;

    // bits-per-pixel modes
    localparam logic [1:0] BPP_1 = 2'd0;
    localparam logic [1:0] BPP_2 = 2'd1;
    localparam logic [1:0] BPP_4 = 2'd2;
    localparam logic [1:0] BPP_8 = 2'd3;

    // config register indexes (word address bit 2)
    localparam logic REG_BPP_MODE = 1'b0;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [11:0]       wr_data;
    } lut_req_t;

    // leading pixel of a byte, MSB first
    function automatic logic [ADDR_W-1:0] pix_index(input logic [7:0] b,
                                                     input logic [1:0] mode);
        logic [ADDR_W-1:0] r;
        case (mode)
            BPP_1:   r = {7'd0, b[7]};
            BPP_2:   r = {6'd0, b[7:6]};
            BPP_4:   r = {4'd0, b[7:4]};
            BPP_8:   r = b;
            default: r = b;
        endcase
        return r;
    endfunction

    // drop the leading pixel
    function automatic logic [7:0] pix_shift(input logic [7:0] b, input logic [1:0] mode);
        logic [7:0] r;
        case (mode)
            BPP_1:   r = {b[6:0], 1'b0};
            BPP_2:   r = {b[5:0], 2'b0};
            BPP_4:   r = {b[3:0], 4'b0};
            BPP_8:   r = 8'd0;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // pixels per byte minus one
    function automatic logic [2:0] pix_count_m1(input logic [1:0] mode);
        logic [2:0] r;
        case (mode)
            BPP_1:   r = 3'd7;
            BPP_2:   r = 3'd3;
            BPP_4:   r = 3'd1;
            BPP_8:   r = 3'd0;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // entry nibble of a colour; phase three reads as red
    function automatic logic [3:0] nib_get(input logic [11:0] e, input logic [1:0] ph);
        logic [3:0] r;
        case (ph)
            PH_GREEN: r = e[7:4];
            PH_BLUE:  r = e[11:8];
            default:  r = e[3:0];
        endcase
        return r;
    endfunction

    function automatic logic [11:0] nib_put(input logic [11:0] e, input logic [1:0] ph,
                                            input logic [3:0] n);
        logic [11:0] r;
        r = e;
        case (ph)
            PH_GREEN: r[7:4]  = n;
            PH_BLUE:  r[11:8] = n;
            default:  r[3:0]  = n;
        endcase
        return r;
    endfunction

endpackage

/* sv/plpx_lut.sv */
module plpx_lut (
    input  logic               clk,
    input  logic               rst_n,
    input  plpx_pkg::lut_req_t req,
    output logic [11:0]        rd_data
);
    import plpx_pkg::*;

    logic [11:0]            lut_mem [LUT_ENTRIES];
    logic [LUT_ENTRIES-1:0] valid_reg;
    logic [11:0]            data_reg;
    logic                   hit_reg;

    logic                 rd_in_range;
    logic                 wr_in_range;
    logic [LUT_IDX_W-1:0] rd_idx;
    logic [LUT_IDX_W-1:0] wr_idx;

    assign rd_idx      = req.rd_addr[LUT_IDX_W-1:0];
    assign wr_idx      = req.wr_addr[LUT_IDX_W-1:0];
    assign rd_in_range = {1'b0, req.rd_addr} < LUT_LIMIT;
    assign wr_in_range = {1'b0, req.wr_addr} < LUT_LIMIT;

    always_ff @(posedge clk)
    begin
        if (req.wr_en && wr_in_range)
        begin
            lut_mem[wr_idx] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg <= lut_mem[rd_idx];
        end
    end

    // entries never written read as black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr_en && wr_in_range)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= rd_in_range && valid_reg[rd_idx];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : 12'd0;

endmodule

/* sv/palette_lut_port_and_pixel_expand_unit.sv */
// Set address, and a data write of the wrong width: taken without going busy, no result.
// Data write: read-modify-write of the table entry, busy until the entry is written, no result.
// Data read: result in the cycle after acceptance; busy until the result is out.
// Expand: first colour in the cycle after acceptance, then one a cycle; 8, 4, 2 or 1
// colours per byte, limited by the single table read port. Results cannot be stalled.
// Reset: per-entry valid flags make the whole table read black at once; pointer, phase, mode zero.
module palette_lut_port_and_pixel_expand_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  value,
    input  logic        single_byte,
    output logic        result_valid,
    output logic        kind,
    output logic [7:0]  read_data,
    output logic [23:0] pixel_color,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import plpx_pkg::*;

    `include "palette_lut_port_and_pixel_expand_unit_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DATA = 2'd1;
    localparam logic [1:0] S_EXP  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [1:0]        phase_reg, phase_next;
    logic [1:0]        bpp_reg;
    logic              op_write_reg, op_write_next;
    logic              single_reg, single_next;
    logic [7:0]        val_reg, val_next;
    logic [2:0]        cnt_reg, cnt_next;

    lut_req_t    req;
    logic [11:0] lut_data;
    logic        accept;
    logic        cfg_write;

    plpx_lut u_lut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (lut_data)
    );

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_BPP_MODE);
    assign prdata    = (paddr[2] == REG_BPP_MODE) ? {30'd0, bpp_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= BPP_1;
        end
        else if (cfg_write)
        begin
            bpp_reg <= pwdata[1:0];
        end
    end

    // last colour cycle frees the read port for the next byte
    assign busy   = (state_reg == S_DATA) || ((state_reg == S_EXP) && (cnt_reg != 3'd0));
    assign accept = start && !busy;

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        phase_next    = phase_reg;
        op_write_next = op_write_reg;
        single_next   = single_reg;
        val_next      = val_reg;
        cnt_next      = cnt_reg;
        req.rd_en     = 1'b0;
        req.rd_addr   = ptr_reg;
        req.wr_en     = 1'b0;
        req.wr_addr   = ptr_reg;
        req.wr_data   = nib_put(lut_data, phase_reg, val_reg[7:4]);

        case (state_reg)
            S_DATA:
            begin
                state_next = S_IDLE;
                req.wr_en  = op_write_reg;
                if (single_reg)
                begin
                    if (phase_reg >= PH_BLUE)
                    begin
                        phase_next = PH_RED;
                        ptr_next   = ptr_reg + 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
            S_EXP:
            begin
                if (cnt_reg != 3'd0)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = pix_index(val_reg, bpp_reg);
                    val_next    = pix_shift(val_reg, bpp_reg);
                    cnt_next    = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (accept)
        begin
            case (action)
                ACT_SET_ADDR:
                begin
                    ptr_next   = value;
                    phase_next = PH_RED;
                end
                ACT_WRITE:
                begin
                    if (single_byte)
                    begin
                        req.rd_en     = 1'b1;
                        state_next    = S_DATA;
                        op_write_next = 1'b1;
                        single_next   = 1'b1;
                        val_next      = value;
                    end
                end
                ACT_READ:
                begin
                    req.rd_en     = single_byte;
                    state_next    = S_DATA;
                    op_write_next = 1'b0;
                    single_next   = single_byte;
                end
                default:
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = pix_index(value, bpp_reg);
                    val_next    = pix_shift(value, bpp_reg);
                    cnt_next    = pix_count_m1(bpp_reg);
                    state_next  = S_EXP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ptr_reg      <= '0;
            phase_reg    <= PH_RED;
            op_write_reg <= 1'b0;
            single_reg   <= 1'b0;
            cnt_reg      <= 3'd0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            phase_reg    <= phase_next;
            op_write_reg <= op_write_next;
            single_reg   <= single_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    // results
    assign result_valid = ((state_reg == S_DATA) && !op_write_reg) || (state_reg == S_EXP);
    assign kind         = (state_reg == S_EXP) ? KIND_PIXEL : KIND_READ;
    assign read_data    = ((state_reg == S_DATA) && single_reg)
                          ? {nib_get(lut_data, phase_reg), 4'd0} : 8'd0;
    assign pixel_color  = (state_reg == S_EXP)
                          ? {lut_data[11:8], 4'd0, lut_data[7:4], 4'd0, lut_data[3:0], 4'd0}
                          : 24'd0;
    assign last         = result_valid && ((state_reg == S_DATA) || (cnt_reg == 3'd0));

    `PLPX_NEVER(a_lut_rw_clash, req.rd_en && req.wr_en, "table read and write in one cycle")
    `PLPX_IMPLY(a_wr_in_data, req.wr_en, (state_reg == S_DATA) && op_write_reg && single_reg, "table write outside a data write")
    `PLPX_NEXT(a_read_result, accept && (action == ACT_READ), result_valid && last && (kind == KIND_READ), "data read gave no result")
    `PLPX_NEXT(a_expand_result, accept && (action == ACT_EXPAND), result_valid && (kind == KIND_PIXEL), "expand gave no colour")
    `PLPX_IMPLY(a_last_frees, result_valid && last && (kind == KIND_PIXEL), !busy, "busy after last colour")

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plpx_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  read_data;
        logic [23:0] pixel_color;
        logic        last;
    } colour_out_t;

    typedef struct packed {
        bit          cfg;    // row writes bpp_mode (value[1:0]) instead of sending an item
        logic [1:0]  act;
        logic [7:0]  val;
        logic        sb;
        bit          typed;  // want holds the expected read byte / pixel colour
        logic [23:0] want;
    } step_row_t;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEM_TARGET   = 470;
    localparam int DIRECTED_ROWS = 25;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  action = ACT_SET_ADDR;
    logic [7:0]  value = 8'd0;
    logic        single_byte = 1'b0;
    logic        result_valid;
    logic        kind;
    logic [7:0]  read_data;
    logic [23:0] pixel_color;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the palette, pointer, phase and pixel mode
    logic [11:0] pal_shadow [LUT_ENTRIES];
    logic [7:0]  ptr_shadow;
    logic [1:0]  phase_shadow;
    logic [1:0]  mode_shadow;

    colour_out_t due_colours[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          quiet_left = 0;
    int          work_items = 0;

    palette_lut_port_and_pixel_expand_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .value        (value),
        .single_byte  (single_byte),
        .result_valid (result_valid),
        .kind         (kind),
        .read_data    (read_data),
        .pixel_color  (pixel_color),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [23:0] entry_rgb(input logic [7:0] idx);
        logic [11:0] e;
        if (int'(idx) >= LUT_ENTRIES)
            return 24'd0;
        e = pal_shadow[idx];
        return {e[11:8], 4'h0, e[7:4], 4'h0, e[3:0], 4'h0};
    endfunction

    function automatic void step_phase();
        if (phase_shadow >= PH_BLUE)
        begin
            phase_shadow = PH_RED;
            ptr_shadow   = ptr_shadow + 8'd1;
        end
        else
            phase_shadow = phase_shadow + 2'd1;
    endfunction

    // palette access or byte expansion; queues the colours it gives
    function automatic void predict_palette_item(input logic [1:0] act, input logic [7:0] val,
                                                 input logic sb);
        colour_out_t c;
        int          bpp;
        int          n;
        logic [7:0]  idx;
        logic [3:0]  nib;
        c = '0;
        case (act)
            ACT_SET_ADDR:
            begin
                ptr_shadow   = val;
                phase_shadow = PH_RED;
            end
            ACT_WRITE:
            begin
                if (sb)
                begin
                    if (int'(ptr_shadow) < LUT_ENTRIES)
                    begin
                        case (phase_shadow)
                            PH_GREEN: pal_shadow[ptr_shadow][7:4]  = val[7:4];
                            PH_BLUE:  pal_shadow[ptr_shadow][11:8] = val[7:4];
                            default:  pal_shadow[ptr_shadow][3:0]  = val[7:4];
                        endcase
                    end
                    step_phase();
                end
            end
            ACT_READ:
            begin
                c.kind = KIND_READ;
                c.last = 1'b1;
                if (sb)
                begin
                    if (int'(ptr_shadow) < LUT_ENTRIES)
                    begin
                        case (phase_shadow)
                            PH_GREEN: nib = pal_shadow[ptr_shadow][7:4];
                            PH_BLUE:  nib = pal_shadow[ptr_shadow][11:8];
                            default:  nib = pal_shadow[ptr_shadow][3:0];
                        endcase
                        c.read_data = {nib, 4'h0};
                    end
                    step_phase();
                end
                due_colours.push_back(c);
            end
            default:
            begin
                bpp = 1 << mode_shadow;
                n   = 8 >> mode_shadow;
                for (int k = 0; k < n; k++)
                begin
                    idx           = 8'((int'(val) >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1));
                    c.kind        = KIND_PIXEL;
                    c.read_data   = 8'd0;
                    c.pixel_color = entry_rgb(idx);
                    c.last        = (k == n - 1);
                    due_colours.push_back(c);
                end
            end
        endcase
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [7:0] val, input logic sb,
                             input bit typed, input logic [23:0] want);
        int gap;
        int before_cnt;
        if (quiet_left > 0)
        begin
            gap = 0;
            quiet_left--;
        end
        else
        begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 29) == 0)
                quiet_left = $urandom_range(10, 30);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        value       <= val;
        single_byte <= sb;
        do
            @(posedge clk);
        while (busy);
        before_cnt = due_colours.size();
        predict_palette_item(act, val, sb);
        // hand-typed expectation overrides the shadow for directed rows
        if (typed)
        begin
            for (int i = before_cnt; i < due_colours.size(); i++)
            begin
                if (due_colours[i].kind == KIND_READ)
                    due_colours[i].read_data = want[7:0];
                else
                    due_colours[i].pixel_color = want;
            end
        end
        if (!(act == ACT_WRITE && !sb))
            work_items++;
    endtask

    // stop sending, let every colour come out and the write pipe empty
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (due_colours.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bpp(input logic [1:0] mode);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BPP_MODE, 2'b00};
        pwdata  <= {30'd0, mode};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        mode_shadow = mode;
        // read it back straight away
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[1:0] !== mode)
        begin
            mismatches++;
            $display("%0t: bpp_mode readback expected %0d actual %0d", $time, mode, prdata[1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] pick_addr();
        int r;
        r = $urandom_range(0, 3);
        // mostly low entries, so expansion in the narrow modes hits written colours
        if (r < 2)
            return 8'($urandom_range(0, 15));
        else if (r == 2)
            return 8'($urandom_range(250, 255));
        return 8'($urandom);
    endfunction

    always @(posedge clk)
    begin
        colour_out_t got;
        colour_out_t want;
        if (rst_n && result_valid)
        begin
            got = '{kind, read_data, pixel_color, last};
            if (due_colours.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result kind %0d read_data %h pixel_color %h last %0d",
                         $time, kind, read_data, pixel_color, last);
            end
            else
            begin
                want = due_colours.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    $display("%0t: expected kind %0d read_data %h pixel_color %h last %0d",
                             $time, want.kind, want.read_data, want.pixel_color, want.last);
                    $display("%0t:   actual kind %0d read_data %h pixel_color %h last %0d",
                             $time, got.kind, got.read_data, got.pixel_color, got.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    step_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, ACT_READ,     8'h00, 1'b1, 1'b1, 24'h000000},  // black after reset
        '{1'b0, ACT_EXPAND,   8'hFF, 1'b1, 1'b1, 24'h000000},
        '{1'b0, ACT_SET_ADDR, 8'h00, 1'b1, 1'b0, 24'h000000},
        '{1'b0, ACT_WRITE,    8'hF0, 1'b1, 1'b0, 24'h000000},
        '{1'b0, ACT_WRITE,    8'h5A, 1'b1, 1'b0, 24'h000000},
        '{1'b0, ACT_WRITE,    8'hA5, 1'b1, 1'b0, 24'h000000},
        '{1'b0, ACT_WRITE,    8'h30, 1'b0, 1'b0, 24'h000000},  // wrong width, dropped
        '{1'b0, ACT_SET_ADDR, 8'h00, 1'b0, 1'b0, 24'h000000},
        '{1'b0, ACT_READ,     8'h00, 1'b1, 1'b1, 24'h0000F0},
        '{1'b0, ACT_READ,     8'hFF, 1'b0, 1'b1, 24'h000000},  // wrong width reads zero
        '{1'b0, ACT_READ,     8'h00, 1'b1, 1'b1, 24'h000050},
        '{1'b0, ACT_READ,     8'h00, 1'b1, 1'b1, 24'h0000A0},
        '{1'b0, ACT_SET_ADDR, 8'hFF, 1'b0, 1'b0, 24'h000000},
        '{1'b0, ACT_WRITE,    8'hFF, 1'b1, 1'b0, 24'h000000},
        '{1'b0, ACT_WRITE,    8'hFF, 1'b1, 1'b0, 24'h000000},
        '{1'b0, ACT_WRITE,    8'hFF, 1'b1, 1'b0, 24'h000000},  // pointer wraps to 0
        '{1'b0, ACT_READ,     8'h00, 1'b1, 1'b1, 24'h0000F0},
        '{1'b0, ACT_EXPAND,   8'h80, 1'b1, 1'b0, 24'h000000},
        '{1'b1, ACT_SET_ADDR, {6'd0, BPP_8}, 1'b0, 1'b0, 24'h000000},
        '{1'b0, ACT_EXPAND,   8'hFF, 1'b0, 1'b1, 24'hF0F0F0},
        '{1'b1, ACT_SET_ADDR, {6'd0, BPP_2}, 1'b0, 1'b0, 24'h000000},
        '{1'b0, ACT_EXPAND,   8'hE4, 1'b1, 1'b0, 24'h000000},
        '{1'b1, ACT_SET_ADDR, {6'd0, BPP_4}, 1'b0, 1'b0, 24'h000000},
        '{1'b0, ACT_EXPAND,   8'h1F, 1'b0, 1'b0, 24'h000000},
        '{1'b1, ACT_SET_ADDR, {6'd0, BPP_1}, 1'b0, 1'b0, 24'h000000}
    };

    initial
    begin
        int          pick;
        int          reps;
        logic        sb;
        logic [1:0]  act;
        for (int i = 0; i < LUT_ENTRIES; i++)
            pal_shadow[i] = 12'd0;
        ptr_shadow   = 8'd0;
        phase_shadow = PH_RED;
        mode_shadow  = BPP_1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].cfg)
                write_bpp(directed_rows[i].val[1:0]);
            else
                send_item(directed_rows[i].act, directed_rows[i].val, directed_rows[i].sb,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        while (work_items < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // write into one or more entries; writes of the wrong width are dropped
                send_item(ACT_SET_ADDR, pick_addr(), 1'($urandom_range(0, 1)), 1'b0, 24'd0);
                reps = 3 * $urandom_range(1, 4);
                for (int j = 0; j < reps; j++)
                begin
                    sb = ($urandom_range(0, 9) != 0);
                    send_item(ACT_WRITE, 8'($urandom), sb, 1'b0, 24'd0);
                end
            end
            else if (pick < 60)
            begin
                send_item(ACT_SET_ADDR, pick_addr(), 1'($urandom_range(0, 1)), 1'b0, 24'd0);
                reps = 3 * $urandom_range(1, 3);
                for (int j = 0; j < reps; j++)
                begin
                    sb = ($urandom_range(0, 9) != 0);
                    send_item(ACT_READ, 8'($urandom), sb, 1'b0, 24'd0);
                end
            end
            else if (pick < 88)
            begin
                reps = $urandom_range(1, 6);
                for (int j = 0; j < reps; j++)
                    send_item(ACT_EXPAND, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, 24'd0);
            end
            else if (pick < 93)
                write_bpp(2'($urandom_range(0, 3)));
            else
            begin
                reps = $urandom_range(1, 3);
                for (int j = 0; j < reps; j++)
                begin
                    act = 2'($urandom_range(0, 3));
                    send_item(act, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, 24'd0);
                end
            end
        end

        settle();
        if (mismatches == 0 && due_colours.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
